// ===== rtl/core/fprc_pkg.sv =====
// ----------------------------------------------------------------------------
// fprc_pkg
// Shared types for the FIFO page replacement core: the command word from
// the controller to the datapath and the status word going back.
// ----------------------------------------------------------------------------
package fprc_pkg;

  // Controller to datapath commands
  typedef struct packed {
    logic start;       // latch page, read slot 0, capture victim slot
    logic scan;        // a lookup word is valid on the RAM read port
    logic scan_next;   // read the next slot
    logic write_miss;  // write page into victim slot, advance pointer
    logic load_out;    // update counters and load the result register
  } fprc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic match;     // slot under scan is valid and holds the page
    logic last;      // slot under scan is the last one in use
    logic out_free;  // result register can take a new word this cycle
  } fprc_status_t;

  // Width of the frame count register
  localparam int unsigned CFG_W = 5;
  // Width of the reported frame slot
  localparam int unsigned SLOT_OUT_W = 4;
  // Width of the running counters
  localparam int unsigned CNT_W = 32;

endpackage

// ===== rtl/core/fprc_ram.sv =====
// ----------------------------------------------------------------------------
// fprc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fprc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/fprc_ctrl.sv =====
// ----------------------------------------------------------------------------
// fprc_ctrl
// Controller for the page replacement core: accepts a word, walks the
// frame lookup, runs the miss update and hands the result to the output.
// ----------------------------------------------------------------------------
module fprc_ctrl
  import fprc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  fprc_status_t st,
  output fprc_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && rst_n) begin
          cmd.start = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (st.match) begin
          state_nxt = ST_OUT;
        end else if (st.last) begin
          state_nxt = ST_UPD;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      ST_UPD: begin
        cmd.write_miss = 1'b1;
        state_nxt      = ST_OUT;
      end
      ST_OUT: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Input side is open only when idle and out of reset
  assign in_stall = !rst_n || (state_r != ST_IDLE);

endmodule

// ===== rtl/core/fprc_dpath.sv =====
// ----------------------------------------------------------------------------
// fprc_dpath
// Datapath for the page replacement core: frame store, valid bits, victim
// pointer, frame count register, counters and the result register.
// ----------------------------------------------------------------------------
module fprc_dpath
  import fprc_pkg::*;
#(
  parameter int unsigned FRAMES    = 16,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fprc_cmd_t             cmd,
  output fprc_status_t          st,
  input  logic                  cfg_we,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic [PAGE_BITS-1:0]  in_page_number,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_hit,
  output logic [SLOT_OUT_W-1:0] out_frame_slot,
  output logic                  out_evicted_valid,
  output logic [PAGE_BITS-1:0]  out_evicted_page,
  output logic [CNT_W-1:0]      out_hit_total,
  output logic [CNT_W-1:0]      out_access_total
);

  localparam int unsigned SW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned NW = $clog2(FRAMES + 1);

  // Frame count register and clamped count
  logic [CFG_W-1:0] cfg_r;
  logic [NW-1:0]    nfr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_W'(16);
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (cfg_r == '0) begin
      nfr = NW'(1);
    end else if (32'(cfg_r) > 32'(FRAMES)) begin
      nfr = NW'(FRAMES);
    end else begin
      nfr = NW'(cfg_r);
    end
  end

  // Lookup state
  logic [PAGE_BITS-1:0] page_r;
  logic [SW-1:0]        idx_r;
  logic [SW-1:0]        vic_r;
  logic [SW-1:0]        vptr_r;
  logic [FRAMES-1:0]    valid_r;
  logic                 hit_r;
  logic [SW-1:0]        slot_r;
  logic                 evv_r;
  logic [PAGE_BITS-1:0] evp_r;
  logic [PAGE_BITS-1:0] rd_data;
  logic [SW-1:0]        rd_addr;
  logic [SW-1:0]        vic_wrap;
  logic [SW-1:0]        vptr_adv;

  // Frame store
  assign rd_addr = cmd.start ? '0 : SW'(idx_r + 1'b1);

  fprc_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (FRAMES)
  ) u_frames (
    .clk   (clk),
    .we    (cmd.write_miss),
    .waddr (vic_r),
    .wdata (page_r),
    .re    (cmd.start || cmd.scan_next),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Pointer wrap after a count change, and round-robin advance
  assign vic_wrap = (8'(vptr_r) >= 8'(nfr)) ? '0 : vptr_r;
  assign vptr_adv = ((8'(vic_r) + 8'd1) >= 8'(nfr)) ? '0 : SW'(vic_r + 1'b1);

  // Status back to the controller
  assign st.match    = valid_r[idx_r] && (rd_data == page_r);
  assign st.last     = (8'(idx_r) + 8'd1) == 8'(nfr);
  assign st.out_free = !out_valid || !out_stall;

  // Lookup payload registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      page_r <= in_page_number;
      idx_r  <= '0;
      vic_r  <= vic_wrap;
      hit_r  <= 1'b0;
      evv_r  <= 1'b0;
    end else if (cmd.scan_next) begin
      idx_r <= SW'(idx_r + 1'b1);
    end
    if (cmd.scan && (idx_r == vic_r)) begin
      evp_r <= rd_data;
    end
    if (cmd.scan && st.match) begin
      hit_r  <= 1'b1;
      slot_r <= idx_r;
    end
    if (cmd.write_miss) begin
      slot_r <= vic_r;
      evv_r  <= valid_r[vic_r];
    end
  end

  // Valid bits and victim pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vptr_r  <= '0;
    end else if (cmd.write_miss) begin
      valid_r[vic_r] <= 1'b1;
      vptr_r         <= vptr_adv;
    end
  end

  // Saturating counters
  logic [CNT_W-1:0] hit_cnt_r;
  logic [CNT_W-1:0] acc_cnt_r;
  logic [CNT_W-1:0] hit_cnt_nxt;
  logic [CNT_W-1:0] acc_cnt_nxt;

  assign acc_cnt_nxt = (&acc_cnt_r) ? acc_cnt_r : acc_cnt_r + 1'b1;
  assign hit_cnt_nxt = (hit_r && !(&hit_cnt_r)) ? hit_cnt_r + 1'b1 : hit_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r <= '0;
      acc_cnt_r <= '0;
    end else if (cmd.load_out) begin
      hit_cnt_r <= hit_cnt_nxt;
      acc_cnt_r <= acc_cnt_nxt;
    end
  end

  // Result register
  logic                  ovld_r;
  logic                  ohit_r;
  logic [SLOT_OUT_W-1:0] oslot_r;
  logic                  oevv_r;
  logic [PAGE_BITS-1:0]  oevp_r;
  logic [CNT_W-1:0]      ohits_r;
  logic [CNT_W-1:0]      oacc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (cmd.load_out) begin
      ovld_r <= 1'b1;
    end else if (!out_stall) begin
      ovld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      ohit_r  <= hit_r;
      oslot_r <= SLOT_OUT_W'(slot_r);
      oevv_r  <= evv_r;
      oevp_r  <= evv_r ? evp_r : '0;
      ohits_r <= hit_cnt_nxt;
      oacc_r  <= acc_cnt_nxt;
    end
  end

  assign out_valid         = ovld_r;
  assign out_hit           = ohit_r;
  assign out_frame_slot    = oslot_r;
  assign out_evicted_valid = oevv_r;
  assign out_evicted_page  = oevp_r;
  assign out_hit_total     = ohits_r;
  assign out_access_total  = oacc_r;

endmodule

// ===== rtl/core/fifo_page_replacement_core.sv =====
// ----------------------------------------------------------------------------
// fifo_page_replacement_core
// FIFO page replacement over a set of page frames, one reference per word.
//
//   port group  direction  contents
//   in_*        input      page_number, valid/stall
//   out_*       output     hit, frame_slot, evicted_valid/page, totals
//   cfg_*       input      frames_in_use write (we + data)
//
// The lookup stops at the matching slot on a hit and reads all n frames in
// use on a miss before the victim is written: the lookup reads one frame
// per cycle from the single read port of the frame RAM.
// Reset is synchronous, active low; in_stall is high during reset.
// The result register lets the next word be accepted while a result waits.
// ----------------------------------------------------------------------------
module fifo_page_replacement_core
  import fprc_pkg::*;
#(
  parameter int unsigned FRAMES    = 16,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PAGE_BITS-1:0]  in_page_number,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_hit,
  output logic [SLOT_OUT_W-1:0] out_frame_slot,
  output logic                  out_evicted_valid,
  output logic [PAGE_BITS-1:0]  out_evicted_page,
  output logic [CNT_W-1:0]      out_hit_total,
  output logic [CNT_W-1:0]      out_access_total,
  input  logic                  cfg_we,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  fprc_cmd_t    cmd;
  fprc_status_t st;

  fprc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  fprc_dpath #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_page_number    (in_page_number),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_frame_slot    (out_frame_slot),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_hit_total     (out_hit_total),
    .out_access_total  (out_access_total)
  );

endmodule

// ===== rtl/core/fprc_checker.sv =====
// ----------------------------------------------------------------------------
// fprc_checker
// Port-level checks for the page replacement core, bound to the top level.
// ----------------------------------------------------------------------------
module fprc_checker
  import fprc_pkg::*;
#(
  parameter int unsigned PAGE_BITS = 16
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic                  out_hit,
  input logic                  out_evicted_valid,
  input logic [PAGE_BITS-1:0]  out_evicted_page,
  input logic [CNT_W-1:0]      out_hit_total,
  input logic [CNT_W-1:0]      out_access_total
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_evicted_page)
      && $stable(out_access_total))
    else $error("result word changed while stalled");

  // A hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_evicted_valid)
    else $error("hit reported an eviction");

  // No eviction means a zero evicted page
  a_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evicted_valid |-> out_evicted_page == '0)
    else $error("evicted page not zero without eviction");

  // Hits never outnumber accesses
  a_hits_le_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hit_total <= out_access_total)
    else $error("hit total above access total");

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind fifo_page_replacement_core fprc_checker #(
  .PAGE_BITS (PAGE_BITS)
) u_fprc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_hit           (out_hit),
  .out_evicted_valid (out_evicted_valid),
  .out_evicted_page  (out_evicted_page),
  .out_hit_total     (out_hit_total),
  .out_access_total  (out_access_total)
);

// ===== test/fifo_page_replacement_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fifo_page_replacement_core_tb
// Self-checking bench for the FIFO page replacement core. A driver feeds
// page references from a queue and a monitor checks every result word against
// a behavioral replacement model kept in the bench. The run covers directed
// corner cases and then randomized working sets over several frame counts.
// ----------------------------------------------------------------------------
module fifo_page_replacement_core_tb;
  import fprc_pkg::*;

  localparam int unsigned FRAMES    = 16;
  localparam int unsigned PAGE_BITS = 16;

  // One expected result word
  typedef struct {
    logic                  hit;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  ev_valid;
    logic [PAGE_BITS-1:0]  ev_page;
    logic [CNT_W-1:0]      hit_total;
    logic [CNT_W-1:0]      access_total;
  } page_outcome_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [PAGE_BITS-1:0]  in_page_number = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_hit;
  logic [SLOT_OUT_W-1:0] out_frame_slot;
  logic                  out_evicted_valid;
  logic [PAGE_BITS-1:0]  out_evicted_page;
  logic [CNT_W-1:0]      out_hit_total;
  logic [CNT_W-1:0]      out_access_total;
  logic                  cfg_we = 1'b0;
  logic [CFG_W-1:0]      cfg_wdata = '0;

  fifo_page_replacement_core #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_page_number    (in_page_number),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_frame_slot    (out_frame_slot),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_hit_total     (out_hit_total),
    .out_access_total  (out_access_total),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Replacement state mirrored in the bench
  logic [PAGE_BITS-1:0] frame_page_m [FRAMES];
  bit                   frame_live [FRAMES];
  int unsigned          victim_slot = 0;
  logic [CNT_W-1:0]     hit_count_m = '0;
  logic [CNT_W-1:0]     access_count_m = '0;
  logic [CFG_W-1:0]     frames_cfg = 5'd16;

  logic [PAGE_BITS-1:0] page_q [$];
  page_outcome_t        outcome_q [$];
  int unsigned          queued_count = 0;
  int unsigned          accepted_count = 0;
  int unsigned          checked_count = 0;
  int unsigned          hits_seen = 0;
  int unsigned          evictions_seen = 0;
  int unsigned          settings_used = 1;
  int unsigned          error_count = 0;
  bit                   calm = 1'b0;

  initial begin
    foreach (frame_live[i]) frame_live[i] = 1'b0;
  end

  // Out-of-range frame counts saturate to 1..FRAMES
  function automatic int unsigned frames_active();
    if (frames_cfg == 0) return 1;
    if (frames_cfg > FRAMES) return FRAMES;
    return 32'(frames_cfg);
  endfunction

  // Look up one reference, update the mirrored state, return the result word
  function automatic page_outcome_t apply_reference(input logic [PAGE_BITS-1:0] page);
    page_outcome_t res;
    int unsigned n;
    int unsigned i;
    bit found;
    n = frames_active();
    found = 1'b0;
    res.hit = 1'b0;
    res.slot = '0;
    res.ev_valid = 1'b0;
    res.ev_page = '0;
    for (i = 0; i < n && !found; i++) begin
      if (frame_live[i] && frame_page_m[i] == page) begin
        found = 1'b1;
        res.slot = i[SLOT_OUT_W-1:0];
      end
    end
    if (access_count_m != '1) access_count_m++;
    if (found) begin
      res.hit = 1'b1;
      if (hit_count_m != '1) hit_count_m++;
    end else begin
      // pointer left beyond a shrunk count wraps first
      if (victim_slot >= n) victim_slot = 0;
      res.slot = victim_slot[SLOT_OUT_W-1:0];
      if (frame_live[victim_slot]) begin
        res.ev_valid = 1'b1;
        res.ev_page = frame_page_m[victim_slot];
      end
      frame_page_m[victim_slot] = page;
      frame_live[victim_slot] = 1'b1;
      victim_slot = (victim_slot + 1 >= n) ? 0 : victim_slot + 1;
    end
    res.hit_total = hit_count_m;
    res.access_total = access_count_m;
    return res;
  endfunction

  function automatic bit take_gap();
    return !calm && ($urandom_range(99) < 32);
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      error_count++;
    end
  endfunction

  // Driver: a word is held until accepted, then the next one is offered
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        outcome_q = {outcome_q, apply_reference(in_page_number)};
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (page_q.size() > 0 && !take_gap()) begin
          in_valid <= 1'b1;
          in_page_number <= page_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result word with the oldest expectation
  always @(posedge clk) begin : result_monitor
    page_outcome_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: result word with nothing expected (hit %0b slot %0d)",
                 $time, out_hit, out_frame_slot);
        error_count++;
      end else begin
        want = outcome_q.pop_front();
        check_field("hit", want.hit, out_hit);
        check_field("frame_slot", want.slot, out_frame_slot);
        check_field("evicted_valid", want.ev_valid, out_evicted_valid);
        check_field("evicted_page", want.ev_page, out_evicted_page);
        check_field("hit_total", want.hit_total, out_hit_total);
        check_field("access_total", want.access_total, out_access_total);
        checked_count++;
        if (want.hit) hits_seen++;
        if (want.ev_valid) evictions_seen++;
      end
    end
    out_stall <= take_gap();
  end

  task automatic queue_page(input logic [PAGE_BITS-1:0] page);
    page_q = {page_q, page};
    queued_count++;
  endtask

  // Sender pauses until every expected word has come, then the core settles
  task automatic wait_drained();
    while (accepted_count != queued_count || outcome_q.size() != 0) @(posedge clk);
    repeat (FRAMES + 4) @(posedge clk);
  endtask

  task automatic write_frames(input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    frames_cfg = value;
    settings_used++;
  endtask

  // Random references drawn mostly from a working set a little larger than
  // the frame count, so hits, misses and evictions all occur
  task automatic run_random_phase(input logic [CFG_W-1:0] frames, input int unsigned count);
    logic [PAGE_BITS-1:0] pool [24];
    int unsigned pool_size;
    int unsigned i;
    wait_drained();
    write_frames(frames);
    pool_size = frames_active() + $urandom_range(1, 6);
    for (i = 0; i < pool_size; i++) pool[i] = PAGE_BITS'($urandom_range(16'hFFFF));
    for (i = 0; i < count; i++) begin
      if ($urandom_range(99) < 80) queue_page(pool[$urandom_range(pool_size - 1)]);
      else queue_page(PAGE_BITS'($urandom_range(16'hFFFF)));
    end
  endtask

  // Stimulus sequence
  initial begin : stimulus
    int unsigned i;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Full frame set: page extremes, hit in slot 0, fill, wrap and evict
    queue_page(16'h0000);
    queue_page(16'hFFFF);
    queue_page(16'h0000);
    queue_page(16'hFFFF);
    for (i = 2; i < FRAMES; i++) queue_page(PAGE_BITS'(16'h1000 + i));
    queue_page(16'h0000);
    queue_page(16'hABCD);
    queue_page(16'h0000);

    // Shrink to two: pointer past the count wraps, slot 5 is out of reach
    wait_drained();
    write_frames(5'd2);
    queue_page(16'hFFFF);
    queue_page(16'h1005);
    queue_page(16'h1005);

    // Grow back: the same page now sits in slots 1 and 5, lowest wins
    wait_drained();
    write_frames(5'd16);
    queue_page(16'h1005);
    queue_page(16'h1003);

    run_random_phase(5'd0, 60);
    run_random_phase(5'd1, 60);
    run_random_phase(5'd5, 100);
    wait_drained();
    calm = 1'b1;
    run_random_phase(5'd17, 100);
    wait_drained();
    calm = 1'b0;
    run_random_phase(5'd31, 100);
    run_random_phase(5'd8, 100);
    run_random_phase(CFG_W'($urandom_range(2, 15)), 100);
    run_random_phase(5'd16, 180);

    wait_drained();
    $display("Checked %0d page references: %0d hits, %0d evictions,", checked_count,
             hits_seen, evictions_seen);
    $display("over %0d frame-count settings including 0, 1, 16, 17 and 31.",
             settings_used);
    if (error_count == 0 && outcome_q.size() == 0) begin
      $display("fifo_page_replacement_core_tb: PASS");
    end else begin
      $display("fifo_page_replacement_core_tb: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding", outcome_q.size());
    $display("fifo_page_replacement_core_tb: FAIL");
    $finish;
  end

endmodule

// ===== fifo_page_replacement_core.f =====
rtl/core/fprc_pkg.sv
rtl/core/fprc_ram.sv
rtl/core/fprc_ctrl.sv
rtl/core/fprc_dpath.sv
rtl/core/fifo_page_replacement_core.sv
rtl/core/fprc_checker.sv
test/fifo_page_replacement_core_tb.sv
